// ===== rtl/ostkv_pkg.sv =====
// Package for the ordered key-value table: sizes, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
package ostkv_pkg;
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 64;
    localparam int RANK_W    = 6;
    localparam int COUNT_W   = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_SELECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;
endpackage

// ===== rtl/order_statistic_key_value_table.sv =====
// Ordered key-value table with rank select, kept sorted in two RAMs.
// Select reads the entry at the rank; key operations run a binary search of up to 7
// steps, then write the table where needed, shifting up to CAPACITY-1 entries one at a
// time on insert/delete. One item at a time; busy is high from start until the result
// strobe. Results cannot be stalled.
// Reset (rst_n low, asynchronous) empties the table; RAM contents stay undefined.
`timescale 1ns / 1ps
module order_statistic_key_value_table
    import ostkv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              kind,
    input  logic signed [KEY_W-1:0] key,
    input  logic [VAL_W-1:0]        value_in,
    input  logic [RANK_W-1:0]       rank,
    output logic                    done,
    output logic [1:0]              status,
    output logic [VAL_W-1:0]        value_out,
    output logic [COUNT_W-1:0]      entry_count
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SWAIT, S_CHECK, S_HWAIT, S_HIT,
        S_SHRD, S_SHWAIT, S_SHWR, S_SEL, S_SELW, S_DONE
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [KEY_W-1:0]   key_reg;     // sign-flipped, unsigned order
    logic [VAL_W-1:0]   val_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg, pos_reg, idx_reg;
    logic [CNT_W-1:0]   mid;
    logic [1:0]         status_reg;
    logic [VAL_W-1:0]   vout_reg;
    logic               done_reg;

    logic               we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [KEY_W-1:0]   wkey, rkey;
    logic [VAL_W-1:0]   wval, rval;

    ostkv_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wkey),
        .raddr(raddr), .rdata(rkey)
    );
    ostkv_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_vals (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wval),
        .raddr(raddr), .rdata(rval)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Read address and the single write port, per state.
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg[IDX_W-1:0];
        wkey  = key_reg;
        wval  = val_reg;
        raddr = mid[IDX_W-1:0];
        unique case (state_reg)
            S_CHECK: raddr = pos_reg[IDX_W-1:0];
            S_SEL:   raddr = pos_reg[IDX_W-1:0];
            // The shift read address is held through the wait cycle so the
            // data is still there when it is written back.
            S_SHRD, S_SHWAIT:
            begin
                if (op_reg == OP_INSERT)
                    raddr = IDX_W'(idx_reg - 1'b1);
                else
                    raddr = IDX_W'(idx_reg + 1'b1);
            end
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = idx_reg[IDX_W-1:0];
                wkey  = rkey;
                wval  = rval;
            end
            S_HIT:   we = (op_reg == OP_INSERT);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            vout_reg   <= '0;
            op_reg     <= OP_INSERT;
            key_reg    <= '0;
            val_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= op_t'(kind);
                        key_reg    <= {~key[KEY_W-1], key[KEY_W-2:0]};
                        val_reg    <= value_in;
                        lo_reg     <= '0;
                        hi_reg     <= occ_reg;
                        pos_reg    <= CNT_W'(rank);
                        status_reg <= ST_OK;
                        vout_reg   <= '0;
                        state_reg  <= (op_t'(kind) == OP_SELECT) ? S_SEL : S_SRCH;
                    end
                end
                S_SEL:
                begin
                    state_reg <= S_SELW;
                end
                S_SELW:
                begin
                    if (CNT_W'(pos_reg) < occ_reg)
                        vout_reg <= rval;
                    else
                        status_reg <= ST_ABSENT;
                    state_reg <= S_DONE;
                end
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                        state_reg <= S_SWAIT;
                    else
                    begin
                        pos_reg   <= lo_reg;
                        state_reg <= S_CHECK;
                    end
                end
                S_SWAIT:
                begin
                    if (rkey < key_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    state_reg <= S_SRCH;
                end
                S_CHECK:
                begin
                    state_reg <= S_HWAIT;
                end
                S_HWAIT:
                begin
                    if (pos_reg < occ_reg && rkey == key_reg)
                    begin
                        unique case (op_reg)
                            OP_INSERT: state_reg <= S_HIT;
                            OP_LOOKUP:
                            begin
                                vout_reg  <= rval;
                                state_reg <= S_DONE;
                            end
                            OP_DELETE:
                            begin
                                idx_reg   <= pos_reg;
                                state_reg <= (CNT_W'(pos_reg + 1'b1) < occ_reg)
                                             ? S_SHRD : S_HIT;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        if (occ_reg >= CNT_W'(CAPACITY))
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= occ_reg;
                            occ_reg   <= occ_reg + 1'b1;
                            state_reg <= (occ_reg > pos_reg) ? S_SHRD : S_HIT;
                        end
                    end
                    else
                    begin
                        status_reg <= ST_ABSENT;
                        state_reg  <= S_DONE;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWAIT;
                end
                S_SHWAIT:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    // Move one entry toward the gap, then step the gap.
                    if (op_reg == OP_INSERT)
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= (CNT_W'(idx_reg - 1'b1) > pos_reg) ? S_SHRD : S_HIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (CNT_W'(idx_reg + 2'd2) < occ_reg) ? S_SHRD : S_HIT;
                    end
                end
                S_HIT:
                begin
                    if (op_reg == OP_DELETE)
                        occ_reg <= occ_reg - 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = COUNT_W'(occ_reg);

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result while busy");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> occ_reg == CNT_W'(CAPACITY))
        else $error("full status with free room");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> vout_reg == '0)
        else $error("value on a miss");
`endif
endmodule

// ===== rtl/ostkv_ram.sv =====
// Simple dual-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ostkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
